### src/isq_pkg.sv
// ----------------------------------------------------------------------------
// isq_pkg
// Shared constants for the integer square root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package isq_pkg;

    // Width of the emitted root field; wider roots wrap to these low bits.
    localparam int ROOT_WIDTH = 16;

    // Root digits resolved in each pipeline stage.
    localparam int STEPS_PER_STAGE = 2;

endpackage : isq_pkg

`default_nettype wire

### src/integer_square_root_core.sv
// ----------------------------------------------------------------------------
// integer_square_root_core
// Pipelined floor square root of an unsigned radicand, one request per cycle while out_ready is high.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ------------------------------
//  input     in         in_valid / in_ready   radicand [RADICAND_WIDTH-1:0]
//  output    out        out_valid / out_ready root [15:0]
//
//  Rate: one request enters per cycle while out_ready is high; the digit
//  pipeline resolves two root bits per stage (eight stages at the
//  default width of 32).
//  Reset: rst_n clears only the stage valid bits; no clearing pass.
//  Stalls: a low out_ready holds the unbroken run of full stages at the
//  output end; ready ripples back so empty stages still fill, and nothing is dropped or repeated.
//
// The radicand is zero-extended to an even width; each stage brings down
// bit pairs and performs restoring digit steps on a narrow remainder.
// Roots wider than 16 bits wrap to their low 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_square_root_core #(
    parameter int RADICAND_WIDTH = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [RADICAND_WIDTH-1:0] radicand,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [isq_pkg::ROOT_WIDTH-1:0] root
);

    // Root bits, even-padded radicand width and stage count.
    localparam int ROOT_BITS  = (RADICAND_WIDTH + 1) / 2;
    localparam int PAD_WIDTH  = 2 * ROOT_BITS;
    localparam int NUM_STAGES =
        (ROOT_BITS + isq_pkg::STEPS_PER_STAGE - 1) / isq_pkg::STEPS_PER_STAGE;

    // Index 0 is the input port side; index NUM_STAGES is the last register.
    logic                 valid_s [0:NUM_STAGES];
    logic                 ready_s [0:NUM_STAGES];
    logic [PAD_WIDTH-1:0] rad_s   [0:NUM_STAGES];
    logic [ROOT_BITS:0]   rem_s   [0:NUM_STAGES];
    logic [ROOT_BITS-1:0] root_s  [0:NUM_STAGES];

    // Feed the first stage with the padded radicand and a clear remainder.
    assign valid_s[0] = in_valid;
    assign in_ready   = ready_s[0];
    assign rad_s[0]   = PAD_WIDTH'(radicand);
    assign rem_s[0]   = '0;
    assign root_s[0]  = '0;

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        // The last stage takes whatever digits remain.
        localparam int LEFT  = ROOT_BITS - s * isq_pkg::STEPS_PER_STAGE;
        localparam int STEPS = (LEFT < isq_pkg::STEPS_PER_STAGE)
                             ? LEFT : isq_pkg::STEPS_PER_STAGE;

        isq_stage #(
            .PAD_WIDTH (PAD_WIDTH),
            .ROOT_BITS (ROOT_BITS),
            .STEPS     (STEPS)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_s[s]),
            .in_ready  (ready_s[s]),
            .in_rad    (rad_s[s]),
            .in_rem    (rem_s[s]),
            .in_root   (root_s[s]),
            .out_valid (valid_s[s+1]),
            .out_ready (ready_s[s+1]),
            .out_rad   (rad_s[s+1]),
            .out_rem   (rem_s[s+1]),
            .out_root  (root_s[s+1])
        );
    end

    // Drive the result channel from the last stage; wrap or extend the root.
    assign ready_s[NUM_STAGES] = out_ready;
    assign out_valid           = valid_s[NUM_STAGES];
    assign root                = isq_pkg::ROOT_WIDTH'(root_s[NUM_STAGES]);

    // A downstream that takes results never back-pressures the input.
    a_ready_passes : assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output is ready");

    // A refused request means every stage is full and the output blocked.
    a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |-> (out_valid && !out_ready))
        else $error("input stalled with room in the pipeline");

    // A finished root leaves a remainder of at most twice the root.
    a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rem_s[NUM_STAGES] <= {root_s[NUM_STAGES], 1'b0}))
        else $error("final remainder exceeds twice the root");

    // Every radicand bit pair has been consumed by the last stage.
    a_rad_spent : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rad_s[NUM_STAGES] == '0))
        else $error("radicand bits left unconsumed");

endmodule : integer_square_root_core

`default_nettype wire

### src/isq_stage.sv
// ----------------------------------------------------------------------------
// isq_stage
// One register stage of the digit pipeline: resolves a few root bits by
// restoring digit steps and holds the partial result under valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

module isq_stage #(
    parameter int PAD_WIDTH  = 32,
    parameter int ROOT_BITS  = 16,
    parameter int STEPS      = 2
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [PAD_WIDTH-1:0]  in_rad,
    input  wire logic [ROOT_BITS:0]    in_rem,
    input  wire logic [ROOT_BITS-1:0]  in_root,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [PAD_WIDTH-1:0]       out_rad,
    output logic [ROOT_BITS:0]         out_rem,
    output logic [ROOT_BITS-1:0]       out_root
);

    localparam int CAND_WIDTH = ROOT_BITS + 3;

    logic                  valid_reg;
    logic [PAD_WIDTH-1:0]  rad_reg;
    logic [ROOT_BITS:0]    rem_reg;
    logic [ROOT_BITS-1:0]  root_reg;

    logic [PAD_WIDTH-1:0]  rad_next;
    logic [ROOT_BITS:0]    rem_next;
    logic [ROOT_BITS-1:0]  root_next;

    logic [PAD_WIDTH-1:0]  rad_c  [0:STEPS];
    logic [ROOT_BITS:0]    rem_c  [0:STEPS];
    logic [ROOT_BITS-1:0]  root_c [0:STEPS];
    logic [CAND_WIDTH-1:0] cand   [0:STEPS-1];
    logic [CAND_WIDTH-1:0] trial  [0:STEPS-1];
    logic [CAND_WIDTH-1:0] diff   [0:STEPS-1];

    // Take a new request whenever this stage is empty or drains this cycle.
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        rad_c[0]  = in_rad;
        rem_c[0]  = in_rem;
        root_c[0] = in_root;
        for (int k = 0; k < STEPS; k++)
        begin
            // Bring down the next pair of radicand bits and try root:01.
            cand[k]  = {rem_c[k], rad_c[k][PAD_WIDTH-1:PAD_WIDTH-2]};
            trial[k] = {1'b0, root_c[k], 2'b01};
            diff[k]  = cand[k] - trial[k];
            rad_c[k+1] = {rad_c[k][PAD_WIDTH-3:0], 2'b00};
            if (cand[k] >= trial[k])
            begin
                rem_c[k+1]  = diff[k][ROOT_BITS:0];
                root_c[k+1] = {root_c[k][ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_c[k+1]  = cand[k][ROOT_BITS:0];
                root_c[k+1] = {root_c[k][ROOT_BITS-2:0], 1'b0};
            end
        end
        rad_next  = rad_c[STEPS];
        rem_next  = rem_c[STEPS];
        root_next = root_c[STEPS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule : isq_stage

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pipelined integer square root core.
//
// Drives radicands through the valid/ready input channel. A bit-level
// predictor works out the floor root of each accepted request and keeps the
// roots in arrival order. Each root leaving the output channel is compared
// with the oldest one. Both channels idle at random but for the gap-free test.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Same width as the core's default build.
    localparam int RADICAND_WIDTH = 32;
    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 9;
    // Pipeline depth is eight stages at 32 bits; the settle wait outlasts that depth.
    localparam int SETTLE_CYCLES  = 40;
    // Watchdog limit; the worst case has both sides stalling.
    localparam int CYCLE_LIMIT    = 200000;

    // Ways of shaping a random radicand.
    typedef enum logic [1:0] {
        SHAPE_UNIFORM,
        SHAPE_NEAR_SQUARE,
        SHAPE_SMALL,
        SHAPE_HIGH
    } radicand_shape_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic [RADICAND_WIDTH-1:0]      radicand  = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [isq_pkg::ROOT_WIDTH-1:0] root;

    // Roots predicted for accepted requests, oldest first.
    logic [isq_pkg::ROOT_WIDTH-1:0] expected_roots[$];

    int unsigned cycle_count    = 0;
    int unsigned error_count    = 0;
    int unsigned requests_sent  = 0;
    int unsigned roots_checked  = 0;
    // Clear to run both channels flat out.
    bit          idling_on      = 1'b1;

    integer_square_root_core #(
        .RADICAND_WIDTH(RADICAND_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .radicand (radicand),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .root     (root)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Watchdog: end the run if something hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d roots still due",
                     cycle_count, expected_roots.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Floor square root by restoring digit steps over a 64-bit field.
    // Mask the radicand to the configured width first, then keep only the
    // low bits of the root that fit the output field.
    function automatic logic [isq_pkg::ROOT_WIDTH-1:0] floor_sqrt(input logic [63:0] value);
        logic [64:0] remainder;
        logic [64:0] partial;
        logic [64:0] weight;
        logic [64:0] trial;
        logic [63:0] width_mask;
        width_mask = (RADICAND_WIDTH >= 64) ? '1 : ((64'd1 << RADICAND_WIDTH) - 64'd1);
        remainder  = {1'b0, value & width_mask};
        partial    = '0;
        weight     = 65'd1 << 62;
        for (int step = 0; step < 32; step++)
        begin
            trial = partial + weight;
            if (remainder >= trial)
            begin
                remainder = remainder - trial;
                partial   = (partial >> 1) + weight;
            end
            else
            begin
                partial = partial >> 1;
            end
            weight = weight >> 2;
        end
        return partial[isq_pkg::ROOT_WIDTH-1:0];
    endfunction

    function automatic logic [RADICAND_WIDTH-1:0] draw_radicand();
        radicand_shape_t     shape;
        logic [31:0]         base;
        logic [31:0]         square;
        shape = radicand_shape_t'($urandom_range(0, 3));
        case (shape)
            SHAPE_NEAR_SQUARE:
            begin
                // Land on a perfect square or one either side of it,
                // where the root steps up.
                base   = $urandom_range(0, 65535);
                square = base * base;
                case ($urandom_range(0, 2))
                    0:       return square - 32'd1;
                    1:       return square;
                    default: return square + 32'd1;
                endcase
            end
            SHAPE_SMALL:
                return $urandom_range(0, 1023);
            SHAPE_HIGH:
                return 32'hFFF0_0000 | $urandom_range(0, 32'h000F_FFFF);
            default:
                return $urandom;
        endcase
    endfunction

    // Send one request. Entered and left at a rising edge; valid is left high
    // after acceptance so that a request with no gap follows without a dip.
    task automatic send_radicand(input logic [RADICAND_WIDTH-1:0] value);
        int unsigned gap;
        bit          accepted;
        gap = idling_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        radicand <= value;
        accepted  = 1'b0;
        while (!accepted)
        begin
            // Sample ready mid-cycle, where it holds its value up to the edge.
            @(negedge clk);
            accepted = in_ready;
            if (accepted)
            begin
                expected_roots.push_back(floor_sqrt(64'(value)));
                requests_sent++;
            end
            @(posedge clk);
        end
    endtask

    // Drop valid and hold off until every outstanding root is back.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (expected_roots.size() != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic test_corner_radicands();
        logic [RADICAND_WIDTH-1:0] corners[$];
        corners = '{
            32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
            32'h0000_0004, 32'h0000_0008, 32'h0000_0009, 32'h0000_00FF,
            32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001, 32'h3FFF_FFFF,
            32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
            32'h5555_5555, 32'hFFFE_0000, 32'hFFFE_0001, 32'hFFFE_0002,
            32'hFFFF_FFFE, 32'hFFFF_FFFF
        };
        foreach (corners[i])
        begin
            send_radicand(corners[i]);
        end
    endtask

    task automatic test_random_radicands(input int unsigned count);
        idling_on = 1'b1;
        repeat (count) send_radicand(draw_radicand());
    endtask

    // No gaps on either side: the pipeline should take a request every cycle.
    task automatic test_back_to_back(input int unsigned count);
        idling_on = 1'b0;
        repeat (count) send_radicand(draw_radicand());
        idling_on = 1'b1;
    endtask

    // Send a burst and empty the pipeline fully, then refill it from cold and empty it again.
    task automatic test_drain_then_resume();
        repeat (2)
        begin
            repeat (20) send_radicand(draw_radicand());
            wait_for_drain();
        end
    endtask

    // Result side: stall at random, then take one root and check it against
    // the oldest prediction.
    initial
    begin
        int unsigned                    stall;
        bit                             taken;
        logic [isq_pkg::ROOT_WIDTH-1:0] predicted;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idling_on ? $urandom_range(0, 7) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            taken      = 1'b0;
            while (!taken)
            begin
                @(negedge clk);
                taken = (out_valid === 1'b1);
                if (taken)
                begin
                    if (expected_roots.size() == 0)
                    begin
                        $error("root with no request outstanding: actual %0d", root);
                        error_count++;
                    end
                    else
                    begin
                        predicted = expected_roots.pop_front();
                        roots_checked++;
                        if (root !== predicted)
                        begin
                            $error("root mismatch: expected %0d, actual %0d",
                                   predicted, root);
                            error_count++;
                        end
                    end
                end
                @(posedge clk);
            end
        end
    end

    // Sequence the tests after reset, then wait out the pipeline and report.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_radicands();
        test_random_radicands(150);
        test_back_to_back(80);
        test_drain_then_resume();
        test_random_radicands(130);

        in_valid <= 1'b0;
        while (expected_roots.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_roots.size() != 0)
        begin
            $error("%0d roots never arrived", expected_roots.size());
            error_count++;
        end

        $display("Sent %0d radicands (corners, near squares, full range), checked %0d roots.",
                 requests_sent, roots_checked);
        $display("Covered random stalls on both sides, gap-free streaming and full drains.");
        if (error_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule : tb

### files.f
src/isq_pkg.sv
src/isq_stage.sv
src/integer_square_root_core.sv
test/tb.sv
